### rtl/core/hrbd_pkg.sv
// Package for the heart rate beat detector: register indexes, reset values
// and divider constants. No dependencies.
`timescale 1ns / 1ps

package hrbd_pkg;

  // Default sample width
  localparam int SAMPLE_BITS_DEF = 10;

  // Register port widths
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 16;
  localparam int WINDOW_BITS    = 16;
  localparam int MARGIN_BITS    = 10;
  localparam int INTERVAL_BITS  = 16;
  localparam int TIME_BITS      = 32;
  localparam int RATE_BITS      = 8;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_CALIB_WINDOW = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE      = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_INTERVAL = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_INTERVAL = 8'd3;

  // Register reset values
  localparam logic [WINDOW_BITS-1:0]   CALIB_WINDOW_RST = 16'd3000;
  localparam logic [MARGIN_BITS-1:0]   RELEASE_RST      = 10'd20;
  localparam logic [INTERVAL_BITS-1:0] MIN_INTERVAL_RST = 16'd400;
  localparam logic [INTERVAL_BITS-1:0] MAX_INTERVAL_RST = 16'd1300;

  // Rate divider: 60000 / interval, saturating to 255 for interval <= 234
  localparam logic [INTERVAL_BITS-1:0] RATE_DIVIDEND = 16'd60000;
  localparam logic [INTERVAL_BITS-1:0] RATE_SAT_GAP  = 16'd234;
  localparam logic [RATE_BITS-1:0]     RATE_MAX      = 8'd255;

endpackage

### rtl/core/heart_rate_beat_detector.sv
// Heart rate beat detector: calibration, threshold detection and rate divider
// built around one shared add/subtract unit. Depends on hrbd_pkg.
// One item at a time: in_stall is high from accept until the result is
//   taken, so the next item is accepted only after the previous result
//   leaves the output. Steps run in sequence on the shared adder, one
//   operation per cycle, and the rate divide takes 8 restoring steps on it.
// Reset (rst, synchronous): registers return to defaults, calibration restarts.
`timescale 1ns / 1ps

module heart_rate_beat_detector
  import hrbd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // input item channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [SAMPLE_BITS-1:0]    sample,
  input  logic [TIME_BITS-1:0]      now_ms,
  // result item channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [RATE_BITS-1:0]      rate_bpm,
  output logic                      beat_start,
  output logic                      is_calibrated,
  output logic [SAMPLE_BITS-1:0]    level_threshold,
  // register write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int ALU_BITS = TIME_BITS + 1;
  localparam int DIV_STEPS = RATE_BITS;
  localparam int STEP_BITS = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    S_IDLE, S_LOW, S_HIGH, S_ELAP, S_WCMP, S_MID,
    S_THR, S_GAP, S_GMIN, S_GMAX, S_SAT, S_DIV,
    S_RSUM, S_RCMP, S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [WINDOW_BITS-1:0]   calib_window_ms;
  logic [MARGIN_BITS-1:0]   release_margin;
  logic [INTERVAL_BITS-1:0] min_interval_ms;
  logic [INTERVAL_BITS-1:0] max_interval_ms;

  // detector state
  logic                   window_started;
  logic [TIME_BITS-1:0]   window_start_time;
  logic                   calib_done;
  logic [SAMPLE_BITS-1:0] lowest_seen;
  logic [SAMPLE_BITS-1:0] highest_seen;
  logic [SAMPLE_BITS-1:0] detect_level;
  logic                   in_beat;
  logic [TIME_BITS-1:0]   last_beat_time;
  logic [RATE_BITS-1:0]   held_rate;
  logic                   started;

  // working registers
  logic [SAMPLE_BITS-1:0]   s_hold;
  logic [TIME_BITS-1:0]     now_hold;
  logic [TIME_BITS-1:0]     scratch;
  logic [INTERVAL_BITS-1:0] remainder;
  logic [RATE_BITS-1:0]     quotient;
  logic [STEP_BITS-1:0]     div_step;

  // shared add/subtract unit
  logic [ALU_BITS-1:0] alu_a;
  logic [ALU_BITS-1:0] alu_b;
  logic                alu_sub;
  logic [ALU_BITS-1:0] alu_res;
  logic                alu_borrow;

  // Select unit operands per step
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    unique case (state)
      S_LOW: begin
        alu_a = ALU_BITS'(s_hold);
        alu_b = ALU_BITS'(lowest_seen);
      end
      S_HIGH: begin
        alu_a = ALU_BITS'(highest_seen);
        alu_b = ALU_BITS'(s_hold);
      end
      S_ELAP: begin
        alu_a = ALU_BITS'(now_hold);
        alu_b = ALU_BITS'(window_start_time);
      end
      S_WCMP: begin
        alu_a = ALU_BITS'(calib_window_ms);
        alu_b = ALU_BITS'(scratch);
      end
      S_MID: begin
        alu_a   = ALU_BITS'(lowest_seen);
        alu_b   = ALU_BITS'(highest_seen);
        alu_sub = 1'b0;
      end
      S_THR: begin
        alu_a = ALU_BITS'(detect_level);
        alu_b = ALU_BITS'(s_hold);
      end
      S_GAP: begin
        alu_a = ALU_BITS'(now_hold);
        alu_b = ALU_BITS'(last_beat_time);
      end
      S_GMIN: begin
        alu_a = ALU_BITS'(min_interval_ms);
        alu_b = ALU_BITS'(scratch);
      end
      S_GMAX: begin
        alu_a = ALU_BITS'(scratch);
        alu_b = ALU_BITS'(max_interval_ms);
      end
      S_SAT: begin
        alu_a = ALU_BITS'(RATE_SAT_GAP);
        alu_b = ALU_BITS'(scratch);
      end
      S_DIV: begin
        alu_a = ALU_BITS'(remainder);
        alu_b = ALU_BITS'(scratch[INTERVAL_BITS-1:0]) << div_step;
      end
      S_RSUM: begin
        alu_a   = ALU_BITS'(s_hold);
        alu_b   = ALU_BITS'(release_margin);
        alu_sub = 1'b0;
      end
      S_RCMP: begin
        alu_a = ALU_BITS'(scratch);
        alu_b = ALU_BITS'(detect_level);
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
      end
    endcase
  end

  assign alu_res    = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  assign alu_borrow = alu_res[ALU_BITS-1];

  // Handshake and result ports
  assign in_stall        = (state != S_IDLE);
  assign out_valid       = (state == S_OUT);
  assign cfg_ready       = 1'b1;
  assign rate_bpm        = held_rate;
  assign beat_start      = started;
  assign is_calibrated   = calib_done;
  assign level_threshold = detect_level;

  // Sequencer, detector state and register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      calib_window_ms   <= CALIB_WINDOW_RST;
      release_margin    <= RELEASE_RST;
      min_interval_ms   <= MIN_INTERVAL_RST;
      max_interval_ms   <= MAX_INTERVAL_RST;
      window_started    <= 1'b0;
      window_start_time <= '0;
      calib_done        <= 1'b0;
      lowest_seen       <= '1;
      highest_seen      <= '0;
      detect_level      <= '0;
      in_beat           <= 1'b0;
      last_beat_time    <= '0;
      held_rate         <= '0;
      started           <= 1'b0;
      div_step          <= '0;
    end else begin
      // take register writes; out-of-range indexes are dropped
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_CALIB_WINDOW: calib_window_ms <= cfg_data[WINDOW_BITS-1:0];
          REG_RELEASE:      release_margin  <= cfg_data[MARGIN_BITS-1:0];
          REG_MIN_INTERVAL: min_interval_ms <= cfg_data[INTERVAL_BITS-1:0];
          REG_MAX_INTERVAL: max_interval_ms <= cfg_data[INTERVAL_BITS-1:0];
          default: ;
        endcase
      end

      unique case (state)
        // accept an item; open the window on the first one
        S_IDLE: begin
          if (in_valid) begin
            s_hold   <= sample;
            now_hold <= now_ms;
            started  <= 1'b0;
            if (!window_started) begin
              window_started    <= 1'b1;
              window_start_time <= now_ms;
            end
            state <= calib_done ? S_THR : S_LOW;
          end
        end
        // track minimum and maximum
        S_LOW: begin
          if (alu_borrow) lowest_seen <= s_hold;
          state <= S_HIGH;
        end
        S_HIGH: begin
          if (alu_borrow) highest_seen <= s_hold;
          state <= S_ELAP;
        end
        // elapsed time since window start, modulo 2^32
        S_ELAP: begin
          scratch <= alu_res[TIME_BITS-1:0];
          state   <= S_WCMP;
        end
        // window ends when elapsed exceeds its length
        S_WCMP: begin
          state <= alu_borrow ? S_MID : S_OUT;
        end
        S_MID: begin
          detect_level <= alu_res[SAMPLE_BITS:1];
          calib_done   <= 1'b1;
          state        <= S_THR;
        end
        // rising crossing while no beat is active starts a beat
        S_THR: begin
          state <= (alu_borrow && !in_beat) ? S_GAP : S_RSUM;
        end
        S_GAP: begin
          scratch        <= alu_res[TIME_BITS-1:0];
          last_beat_time <= now_hold;
          in_beat        <= 1'b1;
          started        <= 1'b1;
          state          <= S_GMIN;
        end
        // interval must lie strictly between the limits
        S_GMIN: begin
          state <= alu_borrow ? S_GMAX : S_RSUM;
        end
        S_GMAX: begin
          state <= alu_borrow ? S_SAT : S_RSUM;
        end
        // short intervals saturate; otherwise start the divide
        S_SAT: begin
          if (!alu_borrow) begin
            held_rate <= RATE_MAX;
            state     <= S_RSUM;
          end else begin
            remainder <= RATE_DIVIDEND;
            quotient  <= '0;
            div_step  <= STEP_BITS'(DIV_STEPS - 1);
            state     <= S_DIV;
          end
        end
        // one restoring divide step per cycle, MSB first
        S_DIV: begin
          if (!alu_borrow) remainder <= alu_res[INTERVAL_BITS-1:0];
          quotient <= {quotient[RATE_BITS-2:0], ~alu_borrow};
          if (div_step == '0) begin
            held_rate <= {quotient[RATE_BITS-2:0], ~alu_borrow};
            state     <= S_RSUM;
          end else begin
            div_step <= div_step - 1'b1;
          end
        end
        // beat ends when sample + margin falls below the threshold
        S_RSUM: begin
          scratch <= alu_res[TIME_BITS-1:0];
          state   <= S_RCMP;
        end
        S_RCMP: begin
          if (alu_borrow) in_beat <= 1'b0;
          state <= S_OUT;
        end
        // hold the result until it is taken
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
